### rtl/core/utbu_pkg.sv
package utbu_pkg;

    localparam int BASES_PER_TILE    = 16;
    localparam int POS_W             = 4;
    localparam int NUM_W             = 5;
    localparam int CHAR_W            = 8;
    localparam int CODE_W            = 2;
    localparam int NUM_CODES         = 4;
    localparam int TILE_W            = BASES_PER_TILE * CODE_W;
    localparam int CFG_IDX_W         = 3;
    localparam int DEF_COUNT_WIDTH   = 28;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BASES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_CODE0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_CODE1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_CODE2   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_CODE3   = 3'd5;

    localparam logic [CHAR_W-1:0] RST_CHAR_CODE0 = 8'd116;
    localparam logic [CHAR_W-1:0] RST_CHAR_CODE1 = 8'd99;
    localparam logic [CHAR_W-1:0] RST_CHAR_CODE2 = 8'd97;
    localparam logic [CHAR_W-1:0] RST_CHAR_CODE3 = 8'd103;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [NUM_CODES-1:0][CHAR_W-1:0] t_char_map;
    typedef logic [BASES_PER_TILE-1:0][CHAR_W-1:0] t_char_row;

    typedef struct packed {
        t_char_row        chars;
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] last_pos;
        logic             last;
    } t_tile;

endpackage

### rtl/core/utbu_lane.sv
module utbu_lane
    import utbu_pkg::*;
(
    input  logic [CODE_W-1:0] i_code,
    input  t_char_map         i_char_map,
    output t_char             o_char
);

    assign o_char = i_char_map[i_code];

endmodule

### rtl/core/utbu_merge.sv
module utbu_merge
    import utbu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_tile  i_tile,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_stall,
    output t_char  o_base_char,
    output logic   o_last_base
);

    logic             r_stage_valid;
    t_tile            r_stage;
    logic             r_act_valid;
    t_tile            r_act;
    logic [POS_W-1:0] r_pos;
    logic             done;
    logic             move;

    assign o_full      = r_stage_valid;
    assign o_valid     = r_act_valid;
    assign o_base_char = r_act.chars[r_pos];
    assign o_last_base = r_act.last && (r_pos == r_act.last_pos);
    assign done        = r_act_valid && !i_stall && (r_pos == r_act.last_pos);
    assign move        = r_stage_valid && (!r_act_valid || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
            r_act_valid   <= 1'b0;
            r_pos         <= '0;
        end else begin
            if (i_load) begin
                r_stage_valid <= 1'b1;
            end else if (move) begin
                r_stage_valid <= 1'b0;
            end
            if (move) begin
                r_act_valid <= 1'b1;
                r_pos       <= r_stage.first_pos;
            end else if (done) begin
                r_act_valid <= 1'b0;
            end else if (r_act_valid && !i_stall) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_stage <= i_tile;
        end
        if (move) begin
            r_act <= r_stage;
        end
    end

endmodule

### rtl/core/unaligned_two_bit_base_unpack.sv
// Sixteen lanes map the base codes of a tile, and the row is registered when the tile is accepted.
// With the output idle, an accepted row passes the staging and then the active register.
// Results leave at one base per cycle while the output is not stalled.
// A new tile is accepted while the previous one is emitted; a waiting tile holds off input,
// so no further tile is accepted until the waiting one moves to the active register.
// Synchronous active-low reset restores the register defaults and a one-base request.
module unaligned_two_bit_base_unpack
    import utbu_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [TILE_W-1:0]      i_tile_word,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [CHAR_W-1:0]      o_base_char,
    output logic                   o_last_base,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COUNT_WIDTH-1:0] i_cfg_data
);

    logic [POS_W-1:0]       r_first_offset;
    logic [COUNT_WIDTH-1:0] r_remaining;
    logic                   r_at_first;
    t_char_map              r_char_map;

    logic [POS_W-1:0]       start;
    logic [NUM_W-1:0]       avail;
    logic [NUM_W-1:0]       num;
    logic [NUM_W-1:0]       last_sum;
    logic                   take;
    logic                   produce;
    logic                   cfg_we;
    logic                   full;
    t_char_row              lane_chars;
    t_tile                  tile;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_stall     = full;
    assign take        = i_valid && !o_stall;
    assign produce     = take && (r_remaining != '0);

    assign start    = r_at_first ? r_first_offset : '0;
    assign avail    = NUM_W'(BASES_PER_TILE) - {1'b0, start};
    assign num      = (r_remaining < COUNT_WIDTH'(avail)) ? r_remaining[NUM_W-1:0] : avail;
    assign last_sum = {1'b0, start} + num - 1'b1;

    genvar g;
    generate
        for (g = 0; g < BASES_PER_TILE; g++) begin : g_lane
            utbu_lane u_lane (
                .i_code     (i_tile_word[CODE_W*(BASES_PER_TILE-1-g) +: CODE_W]),
                .i_char_map (r_char_map),
                .o_char     (lane_chars[g])
            );
        end
    endgenerate

    always_comb begin
        tile.chars     = lane_chars;
        tile.first_pos = start;
        tile.last_pos  = last_sum[POS_W-1:0];
        tile.last      = (r_remaining == COUNT_WIDTH'(num));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_offset <= '0;
            r_remaining    <= COUNT_WIDTH'(1);
            r_at_first     <= 1'b1;
            r_char_map[0]  <= RST_CHAR_CODE0;
            r_char_map[1]  <= RST_CHAR_CODE1;
            r_char_map[2]  <= RST_CHAR_CODE2;
            r_char_map[3]  <= RST_CHAR_CODE3;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_FIRST_OFFSET: r_first_offset <= i_cfg_data[POS_W-1:0];
                REG_TOTAL_BASES: begin
                    r_remaining <= i_cfg_data;
                    r_at_first  <= 1'b1;
                end
                REG_CHAR_CODE0:   r_char_map[0] <= i_cfg_data[CHAR_W-1:0];
                REG_CHAR_CODE1:   r_char_map[1] <= i_cfg_data[CHAR_W-1:0];
                REG_CHAR_CODE2:   r_char_map[2] <= i_cfg_data[CHAR_W-1:0];
                REG_CHAR_CODE3:   r_char_map[3] <= i_cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end else if (produce) begin
            r_remaining <= r_remaining - COUNT_WIDTH'(num);
            r_at_first  <= 1'b0;
        end
    end

    utbu_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (produce),
        .i_tile      (tile),
        .o_full      (full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_base_char (o_base_char),
        .o_last_base (o_last_base)
    );

endmodule

### tb/tb_unaligned_two_bit_base_unpack.sv
`timescale 1ns / 100ps

module tb_unaligned_two_bit_base_unpack;
    import utbu_pkg::*;

    localparam int CW = DEF_COUNT_WIDTH;
    localparam int DRAIN = 6;
    localparam int RANDOM_TILES = 270;
    localparam int LIMIT = 500000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_CHAR_CODE3 + 1'b1;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

    typedef enum bit {ROW_REG, ROW_TILE} t_row_kind;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CW-1:0]          data;
        logic [TILE_W-1:0]      tile;
        bit                     known;
        int                     n;
        t_char                  ch;
        bit                     last;
    } t_stim_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [TILE_W-1:0]      i_tile_word = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [CHAR_W-1:0]      o_base_char;
    logic                   o_last_base;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CW-1:0]          i_cfg_data = '0;

    unaligned_two_bit_base_unpack #(.COUNT_WIDTH(CW)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_tile_word (i_tile_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_base_char (o_base_char),
        .o_last_base (o_last_base),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [POS_W-1:0] first_offset = '0;
    logic [CW-1:0]    bases_left = CW'(1);
    bit               at_first_tile = 1'b1;
    t_char_map        char_map = {RST_CHAR_CODE3, RST_CHAR_CODE2, RST_CHAR_CODE1, RST_CHAR_CODE0};

    t_char       pending_chars[$];
    bit          pending_lasts[$];
    t_stim_row   script[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          tile_up = 1'b0;
    bit          cfg_up = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    t_char       want_char;
    bit          want_last;

    function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CW-1:0] data);
        case (idx)
            REG_FIRST_OFFSET: first_offset = data[POS_W-1:0];
            REG_TOTAL_BASES: begin
                bases_left = data;
                at_first_tile = 1'b1;
            end
            REG_CHAR_CODE0: char_map[0] = data[CHAR_W-1:0];
            REG_CHAR_CODE1: char_map[1] = data[CHAR_W-1:0];
            REG_CHAR_CODE2: char_map[2] = data[CHAR_W-1:0];
            REG_CHAR_CODE3: char_map[3] = data[CHAR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int unpack_tile(input logic [TILE_W-1:0] w, output t_char_row chars,
                                       output logic [BASES_PER_TILE-1:0] lasts);
        int start;
        int n;
        int pos;
        logic [CODE_W-1:0] code;
        chars = '0;
        lasts = '0;
        if (bases_left == 0) begin
            return 0;
        end
        start = at_first_tile ? int'(first_offset) : 0;
        n = BASES_PER_TILE - start;
        if (int'(bases_left) < n) begin
            n = int'(bases_left);
        end
        for (int k = 0; k < n; k++) begin
            pos = start + k;
            code = w[TILE_W-1-CODE_W*pos -: CODE_W];
            chars[k] = char_map[code];
            lasts[k] = (k + 1 == n) && (int'(bases_left) == n);
        end
        bases_left = bases_left - CW'(n);
        at_first_tile = 1'b0;
        return n;
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        script.push_back('{ROW_REG, idx, data, '0, 1'b0, 0, '0, 1'b0});
    endfunction

    function automatic void add_tile(input logic [TILE_W-1:0] w);
        script.push_back('{ROW_TILE, '0, '0, w, 1'b0, 0, '0, 1'b0});
    endfunction

    function automatic void add_known(input logic [TILE_W-1:0] w, input int n, input t_char ch,
                                      input bit last);
        script.push_back('{ROW_TILE, '0, '0, w, 1'b1, n, ch, last});
    endfunction

    task automatic settle();
        if (tile_up) begin
            i_valid <= 1'b0;
            tile_up = 1'b0;
        end
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic cfg_release();
        if (cfg_up) begin
            i_cfg_valid <= 1'b0;
            cfg_up = 1'b0;
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        if (!cfg_up) begin
            settle();
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        cfg_up = 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        note_reg_write(idx, data);
    endtask

    task automatic put_tile(input logic [TILE_W-1:0] w, input bit known, input int known_n,
                            input t_char known_ch, input bit known_last, output int produced);
        t_char_row chars;
        logic [BASES_PER_TILE-1:0] lasts;
        int n;
        cfg_release();
        while (gap_left > 0) begin
            @(posedge i_clk);
            gap_left--;
        end
        i_valid <= 1'b1;
        i_tile_word <= w;
        tile_up = 1'b1;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        n = unpack_tile(w, chars, lasts);
        if (known) begin
            for (int k = 0; k < known_n; k++) begin
                pending_chars.push_back(known_ch);
                pending_lasts.push_back(known_last && (k == known_n - 1));
            end
            produced = known_n;
        end else begin
            for (int k = 0; k < n; k++) begin
                pending_chars.push_back(chars[k]);
                pending_lasts.push_back(lasts[k]);
            end
            produced = n;
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
            burst_left--;
        end
        if (gap_left > 0) begin
            i_valid <= 1'b0;
            tile_up = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected word: base_char 0x%02h last_base %0d", o_base_char, o_last_base);
                fail_count++;
            end else begin
                want_char = pending_chars.pop_front();
                want_last = pending_lasts.pop_front();
                if (o_base_char !== want_char) begin
                    $error("base_char expected 0x%02h actual 0x%02h", want_char, o_base_char);
                    fail_count++;
                end
                if (o_last_base !== want_last) begin
                    $error("last_base expected %0d actual %0d", want_last, o_last_base);
                    fail_count++;
                end
            end
        end
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 4));
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF: i_stall <= $urandom_range(0, 1);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            STALL_TOGGLE: i_stall <= !i_stall;
            default: i_stall <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("unaligned_two_bit_base_unpack test failed");
            $finish;
        end
    end

    initial begin
        int got;
        int produced_tiles;
        int needed;
        int cap;
        int n_tiles;
        logic [CW-1:0] word;
        logic [TILE_W-1:0] tile;

        add_known(32'h0000_0000, 1, RST_CHAR_CODE0, 1'b1);
        add_known(32'hFFFF_FFFF, 0, '0, 1'b0);
        add_reg(REG_TOTAL_BASES, CW'(16));
        add_known(32'hFFFF_FFFF, 16, RST_CHAR_CODE3, 1'b1);
        add_reg(REG_FIRST_OFFSET, CW'(15));
        add_reg(REG_TOTAL_BASES, CW'(3));
        add_tile(32'h0000_0003);
        add_tile(32'hA5A5_A5A5);
        add_reg(REG_TOTAL_BASES, '0);
        add_known(32'h1234_5678, 0, '0, 1'b0);
        add_reg(REG_CHAR_CODE0, 28'hFFF_FF00);
        add_reg(REG_CHAR_CODE1, 28'h000_00FF);
        add_reg(REG_CHAR_CODE2, 28'hABC_DE55);
        add_reg(REG_CHAR_CODE3, 28'h543_21AA);
        add_reg(REG_FIRST_OFFSET, 28'hFFF_FFF0);
        add_reg(REG_TOTAL_BASES, COUNT_MAX);
        add_known(32'h0000_0000, 16, 8'h00, 1'b0);
        add_known(32'h5555_5555, 16, 8'hFF, 1'b0);
        add_tile(32'h1B1B_1B1B);
        add_reg(REG_FIRST_OFFSET, CW'(8));
        add_tile(32'hE4E4_E4E4);
        add_reg(REG_TOTAL_BASES, CW'(20));
        add_tile(32'hFFFF_0000);
        add_tile(32'h0F0F_0F0F);
        add_reg(REG_SPARE_LO, COUNT_MAX);
        add_reg(REG_SPARE_LO + 1'b1, '0);
        add_known(32'hFFFF_FFFF, 0, '0, 1'b0);
        add_reg(REG_FIRST_OFFSET, 28'hABC_DEF5);
        add_reg(REG_TOTAL_BASES, CW'(11));
        add_tile(32'h2D2D_2D2D);
        add_reg(REG_CHAR_CODE0, CW'(RST_CHAR_CODE0));
        add_reg(REG_CHAR_CODE1, CW'(RST_CHAR_CODE1));
        add_reg(REG_CHAR_CODE2, CW'(RST_CHAR_CODE2));
        add_reg(REG_CHAR_CODE3, CW'(RST_CHAR_CODE3));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                put_reg(script[i].idx, script[i].data);
            end else begin
                put_tile(script[i].tile, script[i].known, script[i].n, script[i].ch,
                         script[i].last, got);
            end
        end

        produced_tiles = 0;
        while (produced_tiles < RANDOM_TILES) begin
            if ($urandom_range(0, 2) == 0) begin
                word = CW'($urandom);
                case ($urandom_range(0, 5))
                    0: word[POS_W-1:0] = '0;
                    1: word[POS_W-1:0] = '1;
                    default: ;
                endcase
                put_reg(REG_FIRST_OFFSET, word);
            end
            for (int c = 0; c < NUM_CODES; c++) begin
                if ($urandom_range(0, 3) == 0) begin
                    put_reg(REG_CHAR_CODE0 + CFG_IDX_W'(c), CW'($urandom));
                end
            end
            if ($urandom_range(0, 19) == 0) begin
                put_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 1)), CW'($urandom));
            end
            if ($urandom_range(0, 9) != 0) begin
                case ($urandom_range(0, 19))
                    0: word = '0;
                    1: word = COUNT_MAX;
                    2: word = CW'($urandom);
                    3, 4, 5: word = CW'($urandom_range(49, 300));
                    default: word = CW'($urandom_range(1, 48));
                endcase
                put_reg(REG_TOTAL_BASES, word);
            end
            if (bases_left == 0) begin
                needed = 0;
            end else begin
                needed = ((at_first_tile ? int'(first_offset) : 0) + int'(bases_left)
                          + BASES_PER_TILE - 1) / BASES_PER_TILE;
            end
            cap = $urandom_range(1, 10);
            n_tiles = (needed < cap) ? needed : cap;
            if (n_tiles == needed && $urandom_range(0, 4) == 0) begin
                n_tiles += $urandom_range(1, 2);
            end
            for (int t = 0; t < n_tiles; t++) begin
                case ($urandom_range(0, 15))
                    0: tile = '0;
                    1: tile = '1;
                    default: tile = $urandom;
                endcase
                put_tile(tile, 1'b0, 0, '0, 1'b0, got);
                if (got > 0) begin
                    produced_tiles++;
                end
            end
        end

        cfg_release();
        settle();
        repeat (4 * DRAIN) @(posedge i_clk);
        if (fail_count == 0 && pending_chars.size() == 0) begin
            $display("unaligned_two_bit_base_unpack test passed");
        end else begin
            $display("unaligned_two_bit_base_unpack test failed");
        end
        $finish;
    end

endmodule
